>>> hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the lexer modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge while reset is released.
`define QTL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define QTL_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> hdl/qtl_pkg.sv
// ============================================================================
// Query token lexer package
// Shared types, token codes, keyword table and byte classes.
// ============================================================================
package qtl_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned MAX_KW_LEN_DEF    = 6;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned SLOT_CNT_W = 3;
  localparam int unsigned QDEPTH     = 8;
  localparam int unsigned QPTR_W     = 3;
  localparam int unsigned QCNT_W     = 4;

  localparam logic [5:0] KIND_LPAREN   = 6'd0;
  localparam logic [5:0] KIND_RPAREN   = 6'd1;
  localparam logic [5:0] KIND_LBRACKET = 6'd2;
  localparam logic [5:0] KIND_RBRACKET = 6'd3;
  localparam logic [5:0] KIND_LBRACE   = 6'd4;
  localparam logic [5:0] KIND_RBRACE   = 6'd5;
  localparam logic [5:0] KIND_COMMA    = 6'd6;
  localparam logic [5:0] KIND_DOT      = 6'd7;
  localparam logic [5:0] KIND_SEMI     = 6'd8;
  localparam logic [5:0] KIND_COLON    = 6'd9;
  localparam logic [5:0] KIND_EQUAL    = 6'd10;
  localparam logic [5:0] KIND_GT       = 6'd11;
  localparam logic [5:0] KIND_LT       = 6'd12;
  localparam logic [5:0] KIND_LARROW   = 6'd13;
  localparam logic [5:0] KIND_MINUS    = 6'd14;
  localparam logic [5:0] KIND_RARROW   = 6'd15;
  localparam logic [5:0] KIND_STRING   = 6'd16;
  localparam logic [5:0] KIND_NUMBER   = 6'd17;
  localparam logic [5:0] KIND_IDENT    = 6'd18;
  localparam logic [5:0] KIND_KEY0     = 6'd19;
  localparam logic [5:0] KIND_END      = 6'd34;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam int unsigned KW_COUNT = 15;
  localparam int unsigned KW_CHARS = 6;

  // Keywords are left aligned and padded with spaces.
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "MATCH ", "WHERE ", "RETURN", "DELETE", "SET   ", "CREATE", "ORDER ", "BY    ",
    "LIMIT ", "AND   ", "OR    ", "ASC   ", "DESC  ", "TRUE  ", "FALSE "
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd5, 3'd6, 3'd6, 3'd3, 3'd6, 3'd5, 3'd2,
    3'd5, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5
  };

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_LESS,
    MODE_DASH,
    MODE_STRING,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_IDENT,
    MODE_SKIP
  } mode_e;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         err;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [SLOT_CNT_W-1:0] count;
    res_t [SLOTS-1:0]      slot;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE};
  endfunction

  // Bytes that are not a single-character token map to KIND_END.
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h2E:   k = KIND_DOT;
      8'h3B:   k = KIND_SEMI;
      8'h3A:   k = KIND_COLON;
      8'h3D:   k = KIND_EQUAL;
      8'h3E:   k = KIND_GT;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic res_t make_res(input logic [5:0] kind, input logic [1:0] err,
                                    input logic [FIELD_W-1:0] start,
                                    input logic [FIELD_W-1:0] len,
                                    input logic [FIELD_W-1:0] line,
                                    input logic [FIELD_W-1:0] col);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.col   = col;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/qtl_kw_match.sv
// ============================================================================
// Keyword matcher
// Compares the buffered head of an identifier with the keyword table.
// ============================================================================
module qtl_kw_match #(
  parameter int unsigned POSITION_BITS      = qtl_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_KEYWORD_LENGTH = qtl_pkg::MAX_KW_LEN_DEF
) (
  input  logic [MAX_KEYWORD_LENGTH-1:0][7:0] kw_buf_i,
  input  logic                               too_long_i,
  input  logic [POSITION_BITS-1:0]           len_i,
  output logic [5:0]                         kind_o
);

  logic [qtl_pkg::KW_COUNT-1:0] hit;

  always_comb begin
    for (int k = 0; k < qtl_pkg::KW_COUNT; k++) begin
      hit[k] = !too_long_i && (len_i == POSITION_BITS'(qtl_pkg::KW_LEN[k]));
      for (int j = 0; j < qtl_pkg::KW_CHARS; j++) begin
        if ((3'(j) < qtl_pkg::KW_LEN[k]) &&
            (kw_buf_i[j] != qtl_pkg::KW_TEXT[k][8*(qtl_pkg::KW_CHARS-1-j) +: 8])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    kind_o = qtl_pkg::KIND_IDENT;
    for (int k = 0; k < qtl_pkg::KW_COUNT; k++) begin
      if (hit[k]) begin
        kind_o = 6'(qtl_pkg::KIND_KEY0 + k);
      end
    end
  end

endmodule

>>> hdl/qtl_result_queue.sv
// ============================================================================
// Result queue
// Takes up to four result words per cycle and hands out one per cycle while pop_i is high.
// ============================================================================
`include "assert_macros.svh"

module qtl_result_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qtl_pkg::push_t      push_i,
  input  logic                pop_i,
  output logic                room_o,
  output qtl_pkg::res_t       head_o,
  output logic                valid_o
);

  qtl_pkg::res_t                      mem_q [qtl_pkg::QDEPTH];
  logic [qtl_pkg::QPTR_W-1:0]         wr_q, wr_d;
  logic [qtl_pkg::QPTR_W-1:0]         rd_q, rd_d;
  logic [qtl_pkg::QCNT_W-1:0]         cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= qtl_pkg::QCNT_W'(qtl_pkg::QDEPTH - qtl_pkg::SLOTS));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + qtl_pkg::QPTR_W'(push_i.count);
    rd_d  = rd_q + qtl_pkg::QPTR_W'(pop_i);
    cnt_d = cnt_q + qtl_pkg::QCNT_W'(push_i.count) - qtl_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < qtl_pkg::SLOTS; k++) begin
      if (qtl_pkg::SLOT_CNT_W'(k) < push_i.count) begin
        mem_q[wr_q + qtl_pkg::QPTR_W'(k)] <= push_i.slot[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `QTL_ASSERT(a_fill_bound, clk_i, rst_ni, cnt_q <= qtl_pkg::QCNT_W'(qtl_pkg::QDEPTH), "result queue overfilled")
  `QTL_ASSERT(a_push_room, clk_i, rst_ni, (push_i.count == '0) || room_o, "results pushed without room")

endmodule

>>> hdl/qtl_scan.sv
// ============================================================================
// Lexer scan stage
// Input byte register, scanner state and the per-byte token logic.
// ============================================================================
`include "assert_macros.svh"

module qtl_scan #(
  parameter int unsigned POSITION_BITS      = qtl_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_KEYWORD_LENGTH = qtl_pkg::MAX_KW_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     source_byte_i,
  input  logic           end_of_source_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           room_i,
  output qtl_pkg::push_t push_o
);

  localparam int unsigned IDX_W = $clog2(MAX_KEYWORD_LENGTH);
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] KW_LIMIT = POSITION_BITS'(MAX_KEYWORD_LENGTH);
  localparam logic [15:0] CNT_ONE = 16'd1;

  typedef logic [MAX_KEYWORD_LENGTH-1:0][7:0] kw_buf_t;

  logic                     in_vld_q;
  logic [7:0]               byte_q;
  logic                     eos_q;
  logic                     step;

  qtl_pkg::mode_e           mode_q, mode_d, mode_mid;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] tstart_q, tstart_d;
  logic [15:0]              line_q, line_d;
  logic [15:0]              col_q, col_d;
  logic [15:0]              tcol_q, tcol_d;
  logic                     too_long_q, too_long_d, too_long_w;
  kw_buf_t                  kw_buf_q, kw_buf_d, kw_buf_w;

  logic                     again;
  logic                     char_err;
  logic                     cont;
  logic [POSITION_BITS-1:0] kw_idx;
  logic [POSITION_BITS-1:0] kw_len;
  logic [5:0]               kw_kind;
  logic                     unterm;
  logic [2:0]               res_n;
  qtl_pkg::res_t [qtl_pkg::SLOTS-1:0] res_slot;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] p);
    return (p == '1) ? p : p + POS_ONE;
  endfunction

  function automatic logic [15:0] cnt_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + CNT_ONE;
  endfunction

  function automatic logic [15:0] off16(input logic [POSITION_BITS-1:0] p);
    return 16'(p);
  endfunction

  function automatic logic [15:0] span16(input logic [POSITION_BITS-1:0] a,
                                         input logic [POSITION_BITS-1:0] s);
    logic [POSITION_BITS-1:0] d;
    d = a - s;
    return 16'(d);
  endfunction

  function automatic logic [15:0] span16_dec(input logic [POSITION_BITS-1:0] a,
                                             input logic [POSITION_BITS-1:0] s);
    logic [POSITION_BITS-1:0] d;
    d = a - s;
    if (d != '0) begin
      d = d - POS_ONE;
    end
    return 16'(d);
  endfunction

  // Input byte register.
  assign step       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= source_byte_i;
      eos_q  <= end_of_source_i;
    end
  end

  // Whether the byte starts a new token, and the mode before any end handling.
  always_comb begin
    again    = 1'b1;
    char_err = 1'b0;
    mode_mid = qtl_pkg::MODE_IDLE;
    case (mode_q)
      qtl_pkg::MODE_LESS: begin
        again = (byte_q != qtl_pkg::CH_DASH);
      end
      qtl_pkg::MODE_DASH: begin
        again = (byte_q != qtl_pkg::CH_GREATER);
      end
      qtl_pkg::MODE_STRING: begin
        again    = 1'b0;
        mode_mid = (byte_q == qtl_pkg::CH_QUOTE) ? qtl_pkg::MODE_IDLE : qtl_pkg::MODE_STRING;
      end
      qtl_pkg::MODE_INT: begin
        if (qtl_pkg::is_digit(byte_q)) begin
          again    = 1'b0;
          mode_mid = qtl_pkg::MODE_INT;
        end else if (byte_q == qtl_pkg::CH_DOT) begin
          again    = 1'b0;
          mode_mid = qtl_pkg::MODE_DOT;
        end
      end
      qtl_pkg::MODE_DOT, qtl_pkg::MODE_FRAC: begin
        if (qtl_pkg::is_digit(byte_q)) begin
          again    = 1'b0;
          mode_mid = qtl_pkg::MODE_FRAC;
        end
      end
      qtl_pkg::MODE_IDENT: begin
        if (qtl_pkg::is_word(byte_q)) begin
          again    = 1'b0;
          mode_mid = qtl_pkg::MODE_IDENT;
        end
      end
      qtl_pkg::MODE_SKIP: begin
        again    = 1'b0;
        mode_mid = qtl_pkg::MODE_SKIP;
      end
      default: begin
      end
    endcase
    if (again) begin
      if ((qtl_pkg::single_kind(byte_q) != qtl_pkg::KIND_END) || qtl_pkg::is_blank(byte_q)) begin
        mode_mid = qtl_pkg::MODE_IDLE;
      end else if (byte_q == qtl_pkg::CH_LESS) begin
        mode_mid = qtl_pkg::MODE_LESS;
      end else if (byte_q == qtl_pkg::CH_DASH) begin
        mode_mid = qtl_pkg::MODE_DASH;
      end else if (byte_q == qtl_pkg::CH_QUOTE) begin
        mode_mid = qtl_pkg::MODE_STRING;
      end else if (qtl_pkg::is_digit(byte_q)) begin
        mode_mid = qtl_pkg::MODE_INT;
      end else if (qtl_pkg::is_alpha(byte_q) || (byte_q == qtl_pkg::CH_UNDERSCORE)) begin
        mode_mid = qtl_pkg::MODE_IDENT;
      end else begin
        mode_mid = qtl_pkg::MODE_SKIP;
        char_err = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    mode_d = mode_q;
    if (step) begin
      mode_d = eos_q ? qtl_pkg::MODE_IDLE : mode_mid;
    end
  end

  // Keyword buffer write for a continuing identifier and the length to match.
  always_comb begin
    cont       = (mode_q == qtl_pkg::MODE_IDENT) && qtl_pkg::is_word(byte_q);
    kw_idx     = pos_q - tstart_q;
    kw_buf_w   = kw_buf_q;
    too_long_w = too_long_q;
    kw_len     = kw_idx;
    if (cont) begin
      if (kw_idx < KW_LIMIT) begin
        kw_buf_w[kw_idx[IDX_W-1:0]] = byte_q;
      end else begin
        too_long_w = 1'b1;
      end
      kw_len = pos_inc(pos_q) - tstart_q;
    end
  end

  qtl_kw_match #(
    .POSITION_BITS      (POSITION_BITS),
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
  ) u_kw_match (
    .kw_buf_i   (kw_buf_w),
    .too_long_i (too_long_w),
    .len_i      (kw_len),
    .kind_o     (kw_kind)
  );

  // Result words and counter updates for one byte, in emission order.
  always_comb begin
    pos_d      = pos_q;
    tstart_d   = tstart_q;
    line_d     = line_q;
    col_d      = col_q;
    tcol_d     = tcol_q;
    too_long_d = too_long_w;
    kw_buf_d   = kw_buf_w;
    res_n      = '0;
    res_slot   = '0;
    unterm     = 1'b0;
    if (mode_q != qtl_pkg::MODE_SKIP) begin
      case (mode_q)
        qtl_pkg::MODE_LESS, qtl_pkg::MODE_DASH: begin
          if (!again) begin
            pos_d = pos_inc(pos_d);
            col_d = cnt_inc(col_d);
            res_slot[res_n[1:0]] = qtl_pkg::make_res(
              (mode_q == qtl_pkg::MODE_LESS) ? qtl_pkg::KIND_LARROW : qtl_pkg::KIND_RARROW,
              qtl_pkg::ERR_NONE, off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
          end else begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(
              (mode_q == qtl_pkg::MODE_LESS) ? qtl_pkg::KIND_LT : qtl_pkg::KIND_MINUS,
              qtl_pkg::ERR_NONE, off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
          end
          res_n = res_n + 3'd1;
        end
        qtl_pkg::MODE_STRING: begin
          pos_d = pos_inc(pos_d);
          col_d = cnt_inc(col_d);
          if (byte_q == qtl_pkg::CH_QUOTE) begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_STRING, qtl_pkg::ERR_NONE,
              off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
            res_n = res_n + 3'd1;
          end else if (byte_q == qtl_pkg::CH_NEWLINE) begin
            line_d = cnt_inc(line_d);
            col_d  = CNT_ONE;
          end
        end
        qtl_pkg::MODE_INT, qtl_pkg::MODE_FRAC, qtl_pkg::MODE_IDENT: begin
          if (!again) begin
            pos_d = pos_inc(pos_d);
            col_d = cnt_inc(col_d);
          end else begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(
              (mode_q == qtl_pkg::MODE_IDENT) ? kw_kind : qtl_pkg::KIND_NUMBER,
              qtl_pkg::ERR_NONE, off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
            res_n = res_n + 3'd1;
          end
        end
        qtl_pkg::MODE_DOT: begin
          if (!again) begin
            pos_d = pos_inc(pos_d);
            col_d = cnt_inc(col_d);
          end else begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_NUMBER, qtl_pkg::ERR_NONE,
              off16(tstart_d), span16_dec(pos_d, tstart_d), line_d, tcol_d);
            res_n = res_n + 3'd1;
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_DOT, qtl_pkg::ERR_NONE,
              off16((pos_d == '0) ? pos_d : pos_d - POS_ONE), CNT_ONE, line_d,
              (col_d > CNT_ONE) ? col_d - CNT_ONE : CNT_ONE);
            res_n = res_n + 3'd1;
          end
        end
        default: begin
        end
      endcase

      if (again) begin
        tstart_d = pos_d;
        tcol_d   = col_d;
        pos_d    = pos_inc(pos_d);
        col_d    = cnt_inc(col_d);
        if (byte_q == qtl_pkg::CH_NEWLINE) begin
          line_d = cnt_inc(line_d);
          col_d  = CNT_ONE;
        end
        if (qtl_pkg::single_kind(byte_q) != qtl_pkg::KIND_END) begin
          res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::single_kind(byte_q),
            qtl_pkg::ERR_NONE, off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
          res_n = res_n + 3'd1;
        end else if (char_err) begin
          res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_END, qtl_pkg::ERR_CHAR,
            off16(tstart_d), CNT_ONE, line_d, col_d);
          res_n = res_n + 3'd1;
        end else if (mode_mid == qtl_pkg::MODE_IDENT) begin
          kw_buf_d[0] = byte_q;
          too_long_d  = 1'b0;
        end
      end

      if (eos_q && !char_err) begin
        case (mode_mid)
          qtl_pkg::MODE_LESS, qtl_pkg::MODE_DASH, qtl_pkg::MODE_INT,
          qtl_pkg::MODE_FRAC, qtl_pkg::MODE_IDENT: begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(
              (mode_mid == qtl_pkg::MODE_LESS)  ? qtl_pkg::KIND_LT :
              (mode_mid == qtl_pkg::MODE_DASH)  ? qtl_pkg::KIND_MINUS :
              (mode_mid != qtl_pkg::MODE_IDENT) ? qtl_pkg::KIND_NUMBER :
              again                             ? qtl_pkg::KIND_IDENT : kw_kind,
              qtl_pkg::ERR_NONE, off16(tstart_d), span16(pos_d, tstart_d), line_d, tcol_d);
            res_n = res_n + 3'd1;
          end
          qtl_pkg::MODE_STRING: begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_END, qtl_pkg::ERR_STRING,
              off16(tstart_d), span16(pos_d, tstart_d), line_d, col_d);
            res_n  = res_n + 3'd1;
            unterm = 1'b1;
          end
          qtl_pkg::MODE_DOT: begin
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_NUMBER, qtl_pkg::ERR_NONE,
              off16(tstart_d), span16_dec(pos_d, tstart_d), line_d, tcol_d);
            res_n = res_n + 3'd1;
            res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_DOT, qtl_pkg::ERR_NONE,
              off16((pos_d == '0) ? pos_d : pos_d - POS_ONE), CNT_ONE, line_d,
              (col_d > CNT_ONE) ? col_d - CNT_ONE : CNT_ONE);
            res_n = res_n + 3'd1;
          end
          default: begin
          end
        endcase
        if (!unterm) begin
          res_slot[res_n[1:0]] = qtl_pkg::make_res(qtl_pkg::KIND_END, qtl_pkg::ERR_NONE,
            off16(pos_d), 16'd0, line_d, col_d);
          res_n = res_n + 3'd1;
        end
      end
    end

    if (res_n != '0) begin
      res_slot[2'(res_n - 3'd1)].last = 1'b1;
    end

    // The last byte of a text restarts the scanner.
    if (eos_q) begin
      pos_d      = '0;
      tstart_d   = '0;
      line_d     = CNT_ONE;
      col_d      = CNT_ONE;
      tcol_d     = CNT_ONE;
      too_long_d = 1'b0;
    end
  end

  assign push_o.count = step ? res_n : '0;
  assign push_o.slot  = res_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= qtl_pkg::MODE_IDLE;
      pos_q      <= '0;
      tstart_q   <= '0;
      line_q     <= CNT_ONE;
      col_q      <= CNT_ONE;
      tcol_q     <= CNT_ONE;
      too_long_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      if (step) begin
        pos_q      <= pos_d;
        tstart_q   <= tstart_d;
        line_q     <= line_d;
        col_q      <= col_d;
        tcol_q     <= tcol_d;
        too_long_q <= too_long_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      kw_buf_q <= kw_buf_d;
    end
  end

  `QTL_ASSERT_NEXT(a_end_restart, clk_i, rst_ni, step && eos_q, (mode_q == qtl_pkg::MODE_IDLE) && (pos_q == '0) && (line_q == CNT_ONE), "scanner not restarted after last byte")
  `QTL_ASSERT(a_skip_silent, clk_i, rst_ni, !(step && (mode_q == qtl_pkg::MODE_SKIP)) || (push_o.count == '0), "result emitted while skipping after an error")

endmodule

>>> hdl/query_token_lexer.sv
// ============================================================================
// Query token lexer
// Streaming tokenizer for a small graph query language.
// ============================================================================
// The lexer takes one source byte per cycle. A byte is held in an input
// register while the scan logic closes and opens tokens, and the result
// words it causes, up to four, are written at once into an eight-word
// result queue that hands out one word per cycle while the consumer takes
// them, so the words of a byte pass the input register and the queue
// before they are offered. The input stalls only while the queue has fewer
// than four free words: a steady stream runs at one byte per cycle as long
// as the consumer takes words about as fast as bytes arrive, and a byte
// that causes k words needs k words taken at the output. Tokens that need
// a look-ahead byte close when the next byte arrives or at the last byte,
// which also ends the text and restarts the scanner for the next one.
module query_token_lexer #(
  parameter int unsigned POSITION_BITS      = qtl_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_KEYWORD_LENGTH = qtl_pkg::MAX_KW_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [5:0]  token_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        last_result_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  qtl_pkg::push_t push;
  qtl_pkg::res_t  head;
  logic           room;

  qtl_scan #(
    .POSITION_BITS      (POSITION_BITS),
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .room_i          (room),
    .push_o          (push)
  );

  qtl_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .room_o  (room),
    .head_o  (head),
    .valid_o (out_valid_o)
  );

  assign token_kind_o    = head.kind;
  assign error_code_o    = head.err;
  assign start_offset_o  = head.start;
  assign token_length_o  = head.len;
  assign line_number_o   = head.line;
  assign column_number_o = head.col;
  assign last_result_o   = head.last;

endmodule
